// File: hw/rtl/ir_pulse_distance_frame_decoder_unit_defines.svh
// Assertion macros shared by the checker of the IR frame decoder.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef IR_PULSE_DISTANCE_FRAME_DECODER_UNIT_DEFINES_SVH
`define IR_PULSE_DISTANCE_FRAME_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define IRPD_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("irpd: same-cycle check failed");

// Next-cycle implication.
`define IRPD_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("irpd: next-cycle check failed");

`endif

// File: hw/rtl/irpd_pkg.sv
// Shared types, constants and the window-match function of the IR frame decoder.
// No dependencies; every module of the block imports this package.
`default_nettype none

package irpd_pkg;

  // Field and register widths.
  localparam int unsigned CAPTURE_W  = 16;
  localparam int unsigned INTERVAL_W = CAPTURE_W + 1;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned FRAME_BITS = 32;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned CMD_W      = 8;
  localparam int unsigned CMD_LSB    = 8;
  localparam int unsigned OUT_W      = FRAME_BITS + CMD_W;

  // Register reset values.
  localparam logic [CFG_W-1:0] LEADER_RST    = 16'd442;
  localparam logic [CFG_W-1:0] REPEAT_RST    = 16'd369;
  localparam logic [CFG_W-1:0] ONE_RST       = 16'd74;
  localparam logic [CFG_W-1:0] ZERO_RST      = 16'd37;
  localparam logic [CFG_W-1:0] TOLERANCE_RST = 16'd8;

  // Register indexes on the write port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEADER    = 3'd0,
    CFG_REPEAT    = 3'd1,
    CFG_ONE       = 3'd2,
    CFG_ZERO      = 3'd3,
    CFG_TOLERANCE = 3'd4
  } irpd_cfg_idx_e;

  // Receiver state.
  typedef enum logic {
    ST_WAIT = 1'b0,
    ST_RECV = 1'b1
  } irpd_state_e;

  // Timing registers as seen by the decoder.
  typedef struct packed {
    logic [CFG_W-1:0] leader_ticks;
    logic [CFG_W-1:0] repeat_ticks;
    logic [CFG_W-1:0] one_ticks;
    logic [CFG_W-1:0] zero_ticks;
    logic [CFG_W-1:0] match_tolerance;
  } irpd_cfg_t;

  // True when the interval lies within tolerance of the nominal value.
  function automatic logic window_hit(input logic [INTERVAL_W-1:0] interval,
                                      input logic [CFG_W-1:0]      nominal,
                                      input logic [CFG_W-1:0]      tolerance);
    logic [INTERVAL_W-1:0] nom_ext;
    logic [INTERVAL_W-1:0] diff;
    nom_ext = {1'b0, nominal};
    if (interval >= nom_ext) begin
      diff = interval - nom_ext;
    end else begin
      diff = nom_ext - interval;
    end
    return diff <= {1'b0, tolerance};
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/irpd_cfg_regs.sv
// Timing register bank of the IR frame decoder, written through a plain write port.
// Depends on irpd_pkg.
`default_nettype none

module irpd_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [irpd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [irpd_pkg::CFG_W-1:0]     cfg_wdata_i,
  output irpd_pkg::irpd_cfg_t                 cfg_o
);
  import irpd_pkg::*;

  irpd_cfg_t cfg_q, cfg_d;

  // Decode the register index; unused indexes leave the bank unchanged.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (irpd_cfg_idx_e'(cfg_idx_i))
        CFG_LEADER:    cfg_d.leader_ticks    = cfg_wdata_i;
        CFG_REPEAT:    cfg_d.repeat_ticks    = cfg_wdata_i;
        CFG_ONE:       cfg_d.one_ticks       = cfg_wdata_i;
        CFG_ZERO:      cfg_d.zero_ticks      = cfg_wdata_i;
        CFG_TOLERANCE: cfg_d.match_tolerance = cfg_wdata_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_ticks    <= LEADER_RST;
      cfg_q.repeat_ticks    <= REPEAT_RST;
      cfg_q.one_ticks       <= ONE_RST;
      cfg_q.zero_ticks      <= ZERO_RST;
      cfg_q.match_tolerance <= TOLERANCE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: hw/rtl/irpd_interval.sv
// Input stage: accepts capture beats and registers the wrapped interval to the last capture.
// Depends on irpd_pkg.
`default_nettype none

module irpd_interval (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [irpd_pkg::CAPTURE_W-1:0]  capture_i,
  output logic                                 itv_valid_o,
  output logic [irpd_pkg::INTERVAL_W-1:0]      itv_o,
  input  wire logic                            itv_take_i
);
  import irpd_pkg::*;

  logic                  valid_q, valid_d;
  logic [CAPTURE_W-1:0]  last_q, last_d;
  logic [INTERVAL_W-1:0] itv_q, itv_d;
  logic                  accept;
  logic [CAPTURE_W-1:0]  delta;

  // The stage frees up when its interval moves on to the decoder.
  assign in_ready_o = !valid_q || itv_take_i;
  assign accept     = in_valid_i && in_ready_o;

  // Wrapped difference; equal timestamps mean a full timer period.
  assign delta = capture_i - last_q;

  always_comb begin
    valid_d = valid_q;
    last_d  = last_q;
    itv_d   = itv_q;
    if (accept) begin
      valid_d = 1'b1;
      last_d  = capture_i;
      itv_d   = {capture_i == last_q, delta};
    end else if (itv_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      last_q  <= '0;
    end else begin
      valid_q <= valid_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    itv_q <= itv_d;
  end

  assign itv_valid_o = valid_q;
  assign itv_o       = itv_q;

endmodule

`default_nettype wire

// File: hw/rtl/irpd_frame.sv
// Decoder stage: classifies each interval, runs the receiver state machine, shifts
// in frame bits and holds the finished frame in the output register. Depends on irpd_pkg.
`default_nettype none

module irpd_frame (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire irpd_pkg::irpd_cfg_t            cfg_i,
  input  wire logic                           itv_valid_i,
  input  wire logic [irpd_pkg::INTERVAL_W-1:0] itv_i,
  output logic                                itv_take_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [irpd_pkg::OUT_W-1:0]          out_data_o
);
  import irpd_pkg::*;

  irpd_state_e             state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d, cnt_inc;
  logic [FRAME_BITS-1:0]   shift_q, shift_d;
  logic                    out_valid_q, out_valid_d;
  logic [OUT_W-1:0]        out_data_q, out_data_d;
  logic                    advance;
  logic                    hit_leader, hit_repeat, hit_one, hit_zero;
  logic                    frame_done;
  logic                    emit;

  // An interval is consumed whenever the result register is free or draining.
  assign advance    = itv_valid_i && (!out_valid_q || out_ready_i);
  assign itv_take_o = advance;

  // Window matches against the four nominal intervals.
  assign hit_leader = window_hit(itv_i, cfg_i.leader_ticks, cfg_i.match_tolerance);
  assign hit_repeat = window_hit(itv_i, cfg_i.repeat_ticks, cfg_i.match_tolerance);
  assign hit_one    = window_hit(itv_i, cfg_i.one_ticks, cfg_i.match_tolerance);
  assign hit_zero   = window_hit(itv_i, cfg_i.zero_ticks, cfg_i.match_tolerance);

  assign cnt_inc    = cnt_q + CNT_W'(1);
  assign frame_done = (cnt_inc == CNT_W'(FRAME_BITS));

  // Next state.
  always_comb begin
    state_d = state_q;
    if (advance) begin
      unique case (state_q)
        ST_WAIT: begin
          if (hit_leader) state_d = ST_RECV;
        end
        ST_RECV: begin
          if (!(hit_one || hit_zero) || frame_done) state_d = ST_WAIT;
        end
        default: state_d = ST_WAIT;
      endcase
    end
  end

  // Bit counter, shift register and frame emission.
  always_comb begin
    cnt_d   = cnt_q;
    shift_d = shift_q;
    emit    = 1'b0;
    if (advance) begin
      unique case (state_q)
        ST_WAIT: begin
          if (hit_leader || hit_repeat) cnt_d = '0;
        end
        ST_RECV: begin
          cnt_d = cnt_inc;
          priority if (hit_one) begin
            shift_d = {shift_q[FRAME_BITS-2:0], 1'b1};
            emit    = frame_done;
          end else if (hit_zero) begin
            shift_d = {shift_q[FRAME_BITS-2:0], 1'b0};
            emit    = frame_done;
          end else begin
            cnt_d = '0;
          end
        end
        default: cnt_d = cnt_q;
      endcase
    end
  end

  // Result register: loaded on a finished frame, cleared when the beat is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (advance) begin
      out_valid_d = emit;
      if (emit) out_data_d = {shift_d[CMD_LSB +: CMD_W], shift_d};
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WAIT;
      cnt_q       <= '0;
      shift_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      shift_q     <= shift_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// File: hw/rtl/ir_pulse_distance_frame_decoder_unit.sv
// Top level of the IR pulse-distance frame decoder.
// Depends on irpd_pkg, irpd_cfg_regs, irpd_interval and irpd_frame.
//
// Usage: each beat on the s_axis channel carries one 16-bit timer value
// latched at a falling edge of the IR receiver. The block measures the
// wrapped interval to the previous capture and decodes leader, repeat,
// one and zero intervals. After 32 data bits it sends one beat on m_axis
// with the frame and its command byte; all other captures give no beat.
// Timing registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i
// while no capture is in flight.
// The capture that ends a frame is loaded into the input register when it is
// accepted; the result register is loaded when the decoder takes that interval,
// which waits while an earlier beat is stalled, and m_axis_tvalid then rises.
// Throughput: one capture per cycle unless m_axis stalls (single decode stage).
// Reset clears the receiver to waiting, the last capture to zero and the
// timing registers to their defaults. When the receiver stalls, the result
// register holds its beat; one more capture is buffered in the input
// register, after which s_axis_tready drops until the beat is taken.
`default_nettype none

module ir_pulse_distance_frame_decoder_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration write port.
  input  wire logic                            cfg_we_i,
  input  wire logic [irpd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [irpd_pkg::CFG_W-1:0]      cfg_wdata_i,
  // Capture stream.
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [irpd_pkg::CAPTURE_W-1:0]  s_axis_tdata,  // [15:0] capture_time
  // Frame stream.
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [irpd_pkg::OUT_W-1:0]           m_axis_tdata   // [31:0] frame_code,
                                                              // [39:32] command_byte
);
  import irpd_pkg::*;

  irpd_cfg_t             cfg;
  logic                  itv_valid;
  logic [INTERVAL_W-1:0] itv;
  logic                  itv_take;

  // Timing registers.
  irpd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Input register and interval measurement.
  irpd_interval u_interval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .capture_i   (s_axis_tdata),
    .itv_valid_o (itv_valid),
    .itv_o       (itv),
    .itv_take_i  (itv_take)
  );

  // Decoding and result register.
  irpd_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .itv_valid_i (itv_valid),
    .itv_i       (itv),
    .itv_take_o  (itv_take),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// File: hw/rtl/irpd_checker.sv
// Port-level checks of the IR frame decoder, bound to the top level.
// Depends on irpd_pkg and the assertion macros header.
`default_nettype none

`include "ir_pulse_distance_frame_decoder_unit_defines.svh"

module irpd_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tready,
  input  wire logic                        m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  input  wire logic [irpd_pkg::OUT_W-1:0]  m_axis_tdata
);
  import irpd_pkg::*;

  // A stalled frame beat stays valid and unchanged.
  `IRPD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // The command byte is always bits 15 to 8 of the frame.
  `IRPD_ASSERT_IMP(a_cmd_byte, m_axis_tvalid, m_axis_tdata[FRAME_BITS +: CMD_W] == m_axis_tdata[CMD_LSB +: CMD_W])

  // With the result register empty the block always takes a capture.
  `IRPD_ASSERT_IMP(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)

  // A drained result register keeps the input side open in the next cycle.
  `IRPD_ASSERT_NEXT(a_ready_after_take, m_axis_tvalid && m_axis_tready, s_axis_tready)

endmodule

bind ir_pulse_distance_frame_decoder_unit irpd_checker u_irpd_checker (.*);

`default_nettype wire
